@@ sv/crup_pkg.sv @@
// Package with shared types and constants of the chunk range uniqueness probe.
package crup_pkg;

   localparam int unsigned ColumnsDefault   = 8;
   localparam int unsigned MaxRangesDefault = 16;
   localparam int unsigned ValueWidth       = 64;
   localparam int unsigned CmdWidth         = 2;
   localparam int unsigned ColWidth         = 3;
   localparam int unsigned VerdictWidth     = 2;
   localparam int unsigned CsrWidth         = 8;

   typedef enum logic [1:0] {
      CMD_ELEMENT  = 2'd0,
      CMD_MISMATCH = 2'd1,
      CMD_QUERY    = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      VERDICT_NOT_OBSERVED = 2'd0,
      VERDICT_REFUSED      = 2'd1,
      VERDICT_UNDECIDED    = 2'd2,
      VERDICT_PROVEN       = 2'd3
   } verdict_type;

   typedef enum logic {
      CSR_SELECTED = 1'b0,
      CSR_UNSIGNED = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STORE
   } state_type;

endpackage

@@ sv/chunk_range_uniqueness_probe.sv @@
// Top level of the chunk range uniqueness probe.
// An element or a width-mismatch transaction is handled on acceptance; a query result is registered
// in the output register. A chunk's last element starts a scan of the column's range memory,
// one stored range per cycle, and holds the input (not ready) until the scan and its store step end.
// Other transactions are accepted one per cycle while the output register is free or being read.
// Reset is synchronous, active high; the range memory is not cleared, range counts bound reads.
module chunk_range_uniqueness_probe #(
   parameter int unsigned COLUMNS    = crup_pkg::ColumnsDefault,
   parameter int unsigned MAX_RANGES = crup_pkg::MaxRangesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata: cmd[1:0], column[4:2], value[68:5], is_null[69], integer_type[70], pad
   input  logic [71:0] req_tdata,
   // req_tlast: last_of_chunk
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: column_out[2:0], verdict[4:3], pad
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int unsigned CntW  = $clog2(MAX_RANGES + 1);
   localparam int unsigned RIdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int unsigned CIdxW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int unsigned Depth = COLUMNS * MAX_RANGES;
   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   // Input field split.
   logic [1:0]  in_cmd;
   logic [2:0]  in_col;
   logic [63:0] in_value;
   logic        in_null, in_int, in_last;
   assign in_cmd   = req_tdata[1:0];
   assign in_col   = req_tdata[4:2];
   assign in_value = req_tdata[68:5];
   assign in_null  = req_tdata[69];
   assign in_int   = req_tdata[70];
   assign in_last  = req_tlast;

   // Configuration and per-column flags.
   logic [7:0] sel_ff, uns_ff;
   logic [COLUMNS-1:0] cand_ff, undec_ff, ovl_ff;
   logic [CntW-1:0]    cnt_ff [COLUMNS];

   // Chunk accumulation state.
   logic        busy_ff;
   logic [2:0]  ccol_ff;
   logic [63:0] first_ff, prev_ff;
   logic        sorted_ff, strict_ff, nonull_ff, integer_ff;

   // Scan state.
   crup_pkg::state_type state_ff, state_in;
   logic [CIdxW-1:0] scol_ff;
   logic [RIdxW-1:0] sidx_ff;
   logic [CntW-1:0]  sn_ff;
   logic [63:0]      lo_ff, hi_ff;
   logic             suns_ff;
   logic             rd_valid_ff;

   // Range memories.
   logic [63:0] mem_lo [Depth];
   logic [63:0] mem_hi [Depth];
   logic [63:0] rd_lo_ff, rd_hi_ff;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic             mem_we;

   // Output register.
   logic       out_v_ff;
   logic [2:0] out_col_ff;
   logic [1:0] out_verd_ff;

   logic acc, is_elem, is_mism, is_query;
   logic out_free;
   assign out_free   = !out_v_ff || rsp_tready;
   assign req_tready = (state_ff == crup_pkg::ST_IDLE) && out_free;
   assign acc        = req_tvalid && req_tready;
   assign is_elem    = acc && (in_cmd == crup_pkg::CMD_ELEMENT);
   assign is_mism    = acc && (in_cmd == crup_pkg::CMD_MISMATCH);
   assign is_query   = acc && (in_cmd == crup_pkg::CMD_QUERY);

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {3'b000, out_verd_ff, out_col_ff};

   function automatic logic key_lt(input logic [63:0] a, input logic [63:0] b,
                                   input logic uns);
      logic [63:0] aa, bb;
      aa = uns ? a : {~a[63], a[62:0]};
      bb = uns ? b : {~b[63], b[62:0]};
      return aa < bb;
   endfunction

   // Chunk view including the current element.
   logic [2:0]  e_col;
   logic [63:0] e_first;
   logic        e_sorted, e_strict, e_nonull, e_integer, e_uns;
   always_comb begin
      e_col     = busy_ff ? ccol_ff : in_col;
      e_uns     = uns_ff[e_col];
      e_first   = busy_ff ? first_ff : in_value;
      e_sorted  = busy_ff ? sorted_ff : 1'b1;
      e_strict  = busy_ff ? strict_ff : 1'b1;
      if (busy_ff) begin
         if (key_lt(in_value, prev_ff, e_uns)) begin
            e_sorted = 1'b0;
         end else if (in_value == prev_ff) begin
            e_strict = 1'b0;
         end
      end
      e_nonull  = (busy_ff ? nonull_ff : 1'b1) && !in_null;
      e_integer = (busy_ff ? integer_ff : 1'b1) && in_int;
   end

   logic            e_inrange;
   logic [CIdxW-1:0] e_ci, q_ci;
   assign e_inrange = ({29'd0, e_col} < COLUMNS);
   assign e_ci      = CIdxW'(e_col);
   assign q_ci      = CIdxW'(in_col);

   // Scan bookkeeping: the read at sidx_ff is the last one of the column.
   logic last_read;
   assign last_read = (CntW'(sidx_ff) + CntW'(1) >= sn_ff);

   always_comb begin
      rd_addr = AddrW'(scol_ff * MAX_RANGES + sidx_ff);
      wr_addr = AddrW'(scol_ff * MAX_RANGES + sn_ff);
      mem_we  = (state_ff == crup_pkg::ST_STORE) && (sn_ff < CntW'(MAX_RANGES));
   end

   // Next-state logic for the scan sequencer.
   logic start_scan;
   assign start_scan = is_elem && in_last && e_inrange && cand_ff[e_ci] &&
                       e_nonull && e_integer && e_sorted && e_strict;
   logic rd_issue;
   always_comb begin
      state_in = state_ff;
      rd_issue = 1'b0;
      case (state_ff)
         crup_pkg::ST_IDLE: begin
            if (start_scan) begin
               state_in = crup_pkg::ST_SCAN;
            end
         end
         crup_pkg::ST_SCAN: begin
            rd_issue = (sn_ff != '0);
            if (sn_ff == '0 || last_read) begin
               state_in = crup_pkg::ST_STORE;
            end
         end
         crup_pkg::ST_STORE: state_in = crup_pkg::ST_IDLE;
         default: state_in = crup_pkg::ST_IDLE;
      endcase
   end

   // Memory read and write.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_lo[wr_addr] <= lo_ff;
         mem_hi[wr_addr] <= hi_ff;
      end
      rd_lo_ff <= mem_lo[rd_addr];
      rd_hi_ff <= mem_hi[rd_addr];
   end

   logic overlap_hit;
   assign overlap_hit = rd_valid_ff && !key_lt(rd_hi_ff, lo_ff, suns_ff) &&
                        !key_lt(hi_ff, rd_lo_ff, suns_ff);

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= crup_pkg::ST_IDLE;
         sel_ff      <= '0;
         uns_ff      <= '0;
         cand_ff     <= '0;
         undec_ff    <= '0;
         ovl_ff      <= '0;
         for (int i = 0; i < COLUMNS; i++) cnt_ff[i] <= '0;
         busy_ff     <= 1'b0;
         sorted_ff   <= 1'b1;
         strict_ff   <= 1'b1;
         nonull_ff   <= 1'b1;
         integer_ff  <= 1'b1;
         first_ff    <= '0;
         prev_ff     <= '0;
         ccol_ff     <= '0;
         out_v_ff    <= 1'b0;
         rd_valid_ff <= 1'b0;
         sidx_ff     <= '0;
      end else begin
         state_ff <= state_in;

         // Chunk accumulation.
         if (is_elem) begin
            busy_ff    <= !in_last;
            ccol_ff    <= e_col;
            first_ff   <= e_first;
            prev_ff    <= in_value;
            sorted_ff  <= in_last ? 1'b1 : e_sorted;
            strict_ff  <= in_last ? 1'b1 : e_strict;
            nonull_ff  <= in_last ? 1'b1 : e_nonull;
            integer_ff <= in_last ? 1'b1 : e_integer;
         end
         if (is_mism) begin
            busy_ff    <= 1'b0;
            sorted_ff  <= 1'b1;
            strict_ff  <= 1'b1;
            nonull_ff  <= 1'b1;
            integer_ff <= 1'b1;
            for (int i = 0; i < COLUMNS; i++) begin
               if (cand_ff[i]) begin
                  cand_ff[i] <= 1'b0;
                  ovl_ff[i]  <= 1'b0;
                  cnt_ff[i]  <= '0;
               end
            end
         end

         // Chunk end decisions that need no scan.
         if (is_elem && in_last && e_inrange && cand_ff[e_ci]) begin
            if (!e_nonull || (e_integer && e_sorted && !e_strict)) begin
               cand_ff[e_ci] <= 1'b0;
               ovl_ff[e_ci]  <= 1'b0;
               cnt_ff[e_ci]  <= '0;
            end else if (!e_integer || !e_sorted) begin
               undec_ff[e_ci] <= 1'b1;
            end
         end
         if (start_scan) begin
            scol_ff     <= e_ci;
            sidx_ff     <= '0;
            sn_ff       <= cnt_ff[e_ci];
            lo_ff       <= e_first;
            hi_ff       <= in_value;
            suns_ff     <= e_uns;
            rd_valid_ff <= 1'b0;
         end

         // Range scan: one read issued per cycle, compared in the cycle after.
         if (state_ff == crup_pkg::ST_SCAN) begin
            rd_valid_ff <= rd_issue;
            if (rd_issue && !last_read) sidx_ff <= sidx_ff + RIdxW'(1);
         end
         // The compare of the last read lands in the store cycle.
         if (overlap_hit) ovl_ff[scol_ff] <= 1'b1;
         if (state_ff == crup_pkg::ST_STORE) begin
            rd_valid_ff <= 1'b0;
            if (sn_ff < CntW'(MAX_RANGES)) begin
               cnt_ff[scol_ff] <= sn_ff + CntW'(1);
            end else begin
               undec_ff[scol_ff] <= 1'b1;
            end
         end

         // Query result.
         if (is_query) begin
            out_v_ff   <= 1'b1;
            out_col_ff <= in_col;
            if (({29'd0, in_col} >= COLUMNS) || !sel_ff[in_col]) begin
               out_verd_ff <= crup_pkg::VERDICT_NOT_OBSERVED;
            end else if (!cand_ff[q_ci]) begin
               out_verd_ff <= crup_pkg::VERDICT_REFUSED;
            end else if (undec_ff[q_ci] || ovl_ff[q_ci]) begin
               out_verd_ff <= crup_pkg::VERDICT_UNDECIDED;
            end else begin
               out_verd_ff <= crup_pkg::VERDICT_PROVEN;
            end
         end else if (out_free) begin
            out_v_ff <= 1'b0;
         end

         // A write of the selected-columns register restarts the probe; the unsigned register is only stored.
         if (csr_we) begin
            if (csr_index == crup_pkg::CSR_SELECTED) begin
               sel_ff   <= csr_wdata;
               undec_ff <= '0;
               ovl_ff   <= '0;
               for (int i = 0; i < COLUMNS; i++) begin
                  cand_ff[i] <= (i < 8) ? csr_wdata[i % 8] : 1'b0;
                  cnt_ff[i]  <= '0;
               end
            end else begin
               uns_ff <= csr_wdata;
            end
         end
      end
   end

endmodule

@@ sv/crup_checker.sv @@
// Port-level checker for the chunk range uniqueness probe, bound to the top level.
module crup_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A result that is not taken stays.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // Pad bits of the result are zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:5] == 3'b000)
      else $error("result pad bits set");

   // No input accepted while a stalled result holds the output register.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted over a stalled result");

   // After reset no result is shown.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind chunk_range_uniqueness_probe crup_checker u_crup_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/chunk_range_uniqueness_checker.sv @@
// Checker that predicts and compares the verdicts of the chunk range uniqueness probe.
module chunk_range_uniqueness_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending_verdicts
);

   typedef struct packed {
      logic [2:0]            column;
      crup_pkg::verdict_type verdict;
   } verdict_entry_type;

   // Shadow of the probe state.
   logic [7:0]  sel_mask, uns_mask, cand, undec, ovl;
   int unsigned nranges [8];
   logic [63:0] lows [8][16];
   logic [63:0] highs [8][16];
   logic        in_chunk, ck_sorted, ck_strict, ck_nonull, ck_int;
   logic [63:0] first_val, prev_val;
   logic [2:0]  chunk_col;
   verdict_entry_type verdict_q[$];

   initial pending_verdicts = 0;

   function automatic logic key_less(logic [63:0] a, logic [63:0] b, logic [2:0] c);
      if (!uns_mask[c]) begin
         a[63] = ~a[63];
         b[63] = ~b[63];
      end
      return a < b;
   endfunction

   task automatic restart_probe();
      for (int c = 0; c < 8; c++) begin
         cand[c] = sel_mask[c];
         undec[c] = 1'b0;
         ovl[c] = 1'b0;
         nranges[c] = 0;
      end
   endtask

   task automatic drop_column(int c);
      cand[c] = 1'b0;
      ovl[c] = 1'b0;
      nranges[c] = 0;
   endtask

   // Close the chunk: drop the column, mark it undecided, or check its range for overlap and store it.
   task automatic close_chunk(logic [2:0] c);
      int n;
      if (!cand[c]) return;
      if (!ck_nonull) begin
         drop_column(c);
      end else if (!ck_int || !ck_sorted) begin
         undec[c] = 1'b1;
      end else if (!ck_strict) begin
         drop_column(c);
      end else begin
         n = nranges[c];
         for (int j = 0; j < n; j++)
            if (!key_less(highs[c][j], first_val, c) && !key_less(prev_val, lows[c][j], c))
               ovl[c] = 1'b1;
         if (n < 16) begin
            lows[c][n] = first_val;
            highs[c][n] = prev_val;
            nranges[c] = n + 1;
         end else begin
            undec[c] = 1'b1;
         end
      end
   endtask

   task automatic take_request(logic [71:0] d, logic last);
      crup_pkg::cmd_type cmd;
      logic [2:0]        col;
      logic [63:0]       val;
      verdict_entry_type v;
      cmd = crup_pkg::cmd_type'(d[1:0]);
      col = d[4:2];
      val = d[68:5];
      case (cmd)
         crup_pkg::CMD_ELEMENT: begin
            if (!in_chunk) begin
               in_chunk = 1'b1;
               chunk_col = col;
               first_val = val;
               prev_val = val;
               {ck_sorted, ck_strict, ck_nonull, ck_int} = 4'hF;
            end else begin
               if (key_less(val, prev_val, chunk_col)) ck_sorted = 1'b0;
               else if (val == prev_val) ck_strict = 1'b0;
               prev_val = val;
            end
            if (d[69]) ck_nonull = 1'b0;
            if (!d[70]) ck_int = 1'b0;
            if (last) begin
               close_chunk(chunk_col);
               in_chunk = 1'b0;
               {ck_sorted, ck_strict, ck_nonull, ck_int} = 4'hF;
            end
         end
         crup_pkg::CMD_MISMATCH: begin
            for (int c = 0; c < 8; c++)
               if (cand[c]) drop_column(c);
            in_chunk = 1'b0;
            {ck_sorted, ck_strict, ck_nonull, ck_int} = 4'hF;
         end
         crup_pkg::CMD_QUERY: begin
            v.column = col;
            if (!sel_mask[col]) v.verdict = crup_pkg::VERDICT_NOT_OBSERVED;
            else if (!cand[col]) v.verdict = crup_pkg::VERDICT_REFUSED;
            else if (undec[col] || ovl[col]) v.verdict = crup_pkg::VERDICT_UNDECIDED;
            else v.verdict = crup_pkg::VERDICT_PROVEN;
            verdict_q = {verdict_q, v};
         end
         default: ;
      endcase
   endtask

   // Watch the ports at each rising edge.
   always @(posedge clock) begin
      verdict_entry_type exp_v;
      if (reset) begin
         sel_mask = '0;
         uns_mask = '0;
         restart_probe();
         in_chunk = 1'b0;
         first_val = '0;
         prev_val = '0;
         chunk_col = '0;
         {ck_sorted, ck_strict, ck_nonull, ck_int} = 4'hF;
         verdict_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == crup_pkg::CSR_SELECTED) begin
               sel_mask = csr_wdata;
               restart_probe();
            end else begin
               uns_mask = csr_wdata;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected verdict transaction: %h", rsp_tdata);
            end else begin
               exp_v = verdict_q.pop_front();
               if (rsp_tdata[2:0] !== exp_v.column || rsp_tdata[4:3] !== exp_v.verdict) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("verdict mismatch: expected col %0d verdict %0d, got col %0d verdict %0d",
                              exp_v.column, exp_v.verdict, rsp_tdata[2:0], rsp_tdata[4:3]);
               end
            end
         end
         if (req_tvalid && req_tready) take_request(req_tdata, req_tlast);
      end
      pending_verdicts = verdict_q.size();
   end

endmodule

@@ tb/chunk_range_uniqueness_probe_tb.sv @@
// Testbench top: stimulus, clock, reset and verdict for the chunk range uniqueness probe.
module chunk_range_uniqueness_probe_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = '0;
   int          fail_count;
   int          pending_verdicts;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   longint      cycle_count = 0;

   chunk_range_uniqueness_probe i_dut (.*);
   chunk_range_uniqueness_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("chunk_range_uniqueness_probe test failed");
         $finish;
      end
   end

   // Receiver stalls at random.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Send one transaction; valid stays high until it is taken. A register write or a drain
   // lowers valid again at the following falling edge, the next send only while it idles.
   task automatic send(crup_pkg::cmd_type cmd, logic [2:0] col, logic [63:0] val,
                       logic is_null, logic is_int, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, is_int, is_null, val, col, cmd};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(crup_pkg::csr_index_type idx, logic [7:0] data);
      req_tvalid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until every verdict has arrived and any range scan has ended.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_verdicts != 0) @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // A chunk of random length; half of the time an ascending run, else flawed.
   task automatic send_chunk(logic [2:0] col);
      int          len;
      int          flaw;
      logic [63:0] v;
      len = $urandom_range(1, 5);
      flaw = $urandom_range(9);
      case ($urandom_range(3))
         0: v = rand64();
         1: v = 64'h7FFF_FFFF_FFFF_FFF0 + 64'($urandom_range(15));
         2: v = 64'hFFFF_FFFF_FFFF_FFF0 - 64'($urandom_range(200));
         default: v = 64'($urandom_range(300));
      endcase
      for (int i = 0; i < len; i++) begin
         send(crup_pkg::CMD_ELEMENT, (i != 0 && flaw == 9) ? 3'($urandom) : col, v,
              flaw == 0 && i == len - 1, !(flaw == 1 && i == 0), i == len - 1);
         if (flaw == 2) v = v - 64'($urandom_range(1, 3));
         else if (flaw == 3) v = v + 64'($urandom_range(0, 1));
         else v = v + 64'($urandom_range(1, 40));
      end
   endtask

   initial begin
      logic [2:0] col;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, every command, and the corner cases.
      write_csr(crup_pkg::CSR_SELECTED, 8'hFF);
      write_csr(crup_pkg::CSR_UNSIGNED, 8'h0F);
      send(crup_pkg::CMD_QUERY, 3'd0, '0, 1'b0, 1'b1, 1'b0);
      send(crup_pkg::CMD_ELEMENT, 3'd0, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0);
      send(crup_pkg::CMD_ELEMENT, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1);
      send(crup_pkg::CMD_ELEMENT, 3'd4, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0);
      send(crup_pkg::CMD_ELEMENT, 3'd4, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1);
      send(crup_pkg::CMD_ELEMENT, 3'd4, 64'h0, 1'b0, 1'b1, 1'b1);
      send(crup_pkg::CMD_ELEMENT, 3'd1, 64'd5, 1'b1, 1'b1, 1'b1);
      send(crup_pkg::CMD_ELEMENT, 3'd2, 64'd5, 1'b0, 1'b0, 1'b1);
      send(crup_pkg::CMD_ELEMENT, 3'd3, 64'd9, 1'b0, 1'b1, 1'b0);
      send(crup_pkg::CMD_ELEMENT, 3'd7, 64'd9, 1'b0, 1'b1, 1'b1);
      send(crup_pkg::CMD_ELEMENT, 3'd5, 64'd9, 1'b0, 1'b1, 1'b0);
      send(crup_pkg::CMD_ELEMENT, 3'd5, 64'd3, 1'b0, 1'b1, 1'b1);
      send(crup_pkg::CMD_UNUSED, 3'd7, rand64(), 1'b1, 1'b0, 1'b1);
      for (int c = 0; c < 8; c++) send(crup_pkg::CMD_QUERY, 3'(c), '0, 1'b0, 1'b1, 1'b0);
      send(crup_pkg::CMD_MISMATCH, 3'd0, '0, 1'b0, 1'b1, 1'b0);
      send(crup_pkg::CMD_QUERY, 3'd6, '0, 1'b0, 1'b1, 1'b0);
      drain();

      // Overflow the range store of one column.
      write_csr(crup_pkg::CSR_SELECTED, 8'h01);
      write_csr(crup_pkg::CSR_UNSIGNED, 8'h00);
      for (int i = 0; i < 18; i++)
         send(crup_pkg::CMD_ELEMENT, 3'd0, 64'(i * 10), 1'b0, 1'b1, 1'b1);
      send(crup_pkg::CMD_QUERY, 3'd0, '0, 1'b0, 1'b1, 1'b0);
      drain();

      // Random phases across idling patterns and register settings.
      for (int phase = 0; phase < 12; phase++) begin
         send_idle_pct = (phase < 4) ? 14 : (phase < 8) ? 58 : 0;
         recv_idle_pct = (phase < 4) ? 58 : (phase < 8) ? 14 : 0;
         drain();
         case (phase % 4)
            0: write_csr(crup_pkg::CSR_SELECTED, 8'hFF);
            1: write_csr(crup_pkg::CSR_SELECTED, 8'h00);
            default: write_csr(crup_pkg::CSR_SELECTED, 8'($urandom));
         endcase
         write_csr(crup_pkg::CSR_UNSIGNED,
                   (phase % 3 == 0) ? 8'hFF : (phase % 3 == 1) ? 8'h00 : 8'($urandom));
         for (int k = 0; k < 45; k++) begin
            col = 3'($urandom);
            case ($urandom_range(19))
               0: send(crup_pkg::CMD_MISMATCH, col, rand64(), 1'b0, 1'b1, 1'b0);
               1: send(crup_pkg::CMD_UNUSED, col, rand64(), 1'b1, 1'b0, 1'b1);
               2, 3, 4, 5: send(crup_pkg::CMD_QUERY, col, rand64(), 1'($urandom),
                                1'($urandom), 1'($urandom));
               6: send(crup_pkg::CMD_ELEMENT, col, rand64(), 1'($urandom),
                       1'($urandom), 1'($urandom));
               default: send_chunk(col);
            endcase
         end
         for (int c = 0; c < 8; c++)
            send(crup_pkg::CMD_QUERY, 3'(c), '0, 1'b0, 1'b1, 1'b0);
      end

      drain();
      if (fail_count == 0)
         $display("chunk_range_uniqueness_probe test passed");
      else
         $display("chunk_range_uniqueness_probe test failed");
      $finish;
   end

endmodule
